[hdl/olpr_pkg.sv]
// Package for the ordered list positional remove unit.
// Holds status codes, operation codes, default sizes and the memory write type; no dependencies.
package olpr_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;
  localparam int WORD_W = 32;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic             we;
    logic [10:0]      waddr;
    logic [63:0]      wdata;
  } mem_wr_t;
endpackage

[hdl/ordered_list_positional_remove_unit.sv]
// Ordered list with positional remove: list control and result register.
// Depends on olpr_pkg and olpr_store.
//
// Usage: input items arrive on s_axis (tdata = operation, item_data, position,
// from bit 0 up). An append writes the word at the tail as it is accepted.
// A remove reads the word at the position (position zero counts as one), then
// closes the gap by moving each later entry down one place: one memory read and
// one write per cycle, set by the single memory port pair. Each item gives one
// result on m_axis (tdata = status, removed_data, entry_count). The result
// waits in an output register; while the receiver stalls, the next item is
// accepted and worked on, but its result waits until the register empties.
// Reset clears the count and the control state; the memory is not cleared,
// and only entries below the count are ever used.
// CAPACITY may be 2 to 127 here, since position and count are 7-bit fields.
module ordered_list_positional_remove_unit import olpr_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation[0], item_data[32:1], position[39:33]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], removed_data[33:2], entry_count[40:34]
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [1:0]            res_status;
  logic [WORD_W-1:0]     res_data;
  logic [CNT_W-1:0]      res_count;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  mem_wr_t               wr;
  logic                  out_free;
  logic                  in_fire;
  logic                  in_op;
  logic [WORD_W-1:0]     in_word;
  logic [POS_W-1:0]      in_pos;
  logic [CNT_W-1:0]      pos_idx;

  assign in_op = s_axis_tdata[0];
  assign in_word = s_axis_tdata[32:1];
  assign in_pos = s_axis_tdata[39:33];
  assign pos_idx = (in_pos == '0) ? '0 : in_pos - 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  olpr_store #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_store (
    .clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    raddr = idx[AW-1:0];
    wr = '0;
    if (state == S_IDLE) begin
      raddr = pos_idx[AW-1:0];
      if (in_fire && in_op == OP_APPEND && count < CAP) begin
        wr.we = 1'b1;
        wr.waddr = 11'(count);
        wr.wdata = 64'(in_word[DATA_WIDTH-1:0]);
      end
    end else if (state == S_READ) begin
      raddr = AW'(idx + 1'b1);
    end else if (state == S_SHIFT) begin
      raddr = AW'(idx + 1'b1);
      if (idx != count) begin
        wr.we = 1'b1;
        wr.waddr = 11'(idx - 1'b1);
        wr.wdata = 64'(rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_data <= '0;
            idx <= pos_idx;
            if (in_op == OP_APPEND) begin
              if (count < CAP) begin
                res_status <= ST_OK;
                count <= count + 1'b1;
                res_count <= count + 1'b1;
              end else begin
                res_status <= ST_FULL;
                res_count <= count;
              end
              state <= S_DONE;
            end else if (count == '0) begin
              res_status <= ST_EMPTY;
              res_count <= count;
              state <= S_DONE;
            end else if (in_pos > count) begin
              res_status <= ST_RANGE;
              res_count <= count;
              state <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          res_data <= WORD_W'(rdata);
          idx <= idx + 1'b1;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (idx == count) begin
            count <= count - 1'b1;
            res_count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {7'b0, res_count, res_data, res_status};
            state <= S_IDLE;
          end else if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("count exceeds capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("accept while busy");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx <= count))
    else $error("shift index past count");
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[33:2] == '0))
    else $error("data on failed item");
`endif
endmodule

[hdl/olpr_store.sv]
// Entry memory of the ordered list: one write port, one registered read port.
// Depends on olpr_pkg.
module olpr_store import olpr_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  mem_wr_t               wr,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);
  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr[AW-1:0]] <= wr.wdata[DATA_WIDTH-1:0];
    end
    rdata <= mem[raddr];
  end
endmodule
